/* src/vrf_pkg.sv */
// Package for the variable record ring FIFO: command and status codes,
// front-end state, job and result records shared by all modules but vrf_ram.
// No dependencies.
`timescale 1ns / 1ps

package vrf_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_COMMIT  = 2'd1,
    CMD_DEQUEUE = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic {
    FE_IDLE,
    FE_LOOKUP
  } fe_state_e;

  typedef enum logic {
    REG_SLOT_COUNT      = 1'b0,
    REG_MAX_VALUE_BYTES = 1'b1
  } reg_idx_e;

  localparam int SLOT_COUNT_MAX = 16;   // slot_count register saturates here
  localparam int ROOM_MAX       = 64;   // dequeue room saturates here
  localparam int LEN_W          = 7;    // record length width
  localparam int SLOT_FIELD_W   = 10;   // slot index field, covers 1024 slots
  localparam int QDEPTH         = 2;    // job queue entries

  // One unit of work handed from front to back.
  typedef struct packed {
    logic                    stream;   // 1: stream record bytes, 0: single status
    status_e                 status;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [LEN_W-1:0]        len;
  } job_t;

  // Result fields apart from the data byte.
  typedef struct packed {
    status_e          status;
    logic             byte_valid;
    logic [LEN_W-1:0] value_length;
    logic             last;
  } res_t;

  // Configuration write request from the register port.
  typedef struct packed {
    logic       slot_count_we;
    logic       max_bytes_we;
    logic [6:0] data;
  } cfg_wr_t;

  // Current configuration register contents.
  typedef struct packed {
    logic [4:0] slot_count;
    logic [6:0] max_value_bytes;
  } cfg_view_t;

endpackage

/* src/vrf_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module vrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/vrf_queue.sv */
// Short job queue between the front end and the back end.
// Depends on vrf_pkg (job_t, QDEPTH).
`timescale 1ns / 1ps

module vrf_queue
  import vrf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  job_t           entry_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;
  logic           do_push, do_pop;

  assign full_o     = (count_q == QCW'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/vrf_front.sv */
// Front end: accepts requests, keeps ring pointers and record build state,
// writes appended bytes and committed lengths, and queues jobs for the back end.
// Depends on vrf_pkg and vrf_ram (length store).
`timescale 1ns / 1ps

module vrf_front
  import vrf_pkg::*;
#(
  parameter int SLOT_DEPTH      = 16,
  parameter int MAX_VALUE_BYTES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  input  logic [6:0] room_bytes_i,
  input  cfg_wr_t   cfg_wr_i,
  output cfg_view_t cfg_o,
  output logic      vwe_o,
  output logic [((SLOT_DEPTH * MAX_VALUE_BYTES > 1) ?
                 $clog2(SLOT_DEPTH * MAX_VALUE_BYTES) : 1)-1:0] vwaddr_o,
  output logic [7:0] vwdata_o,
  output logic      job_push_o,
  output job_t      job_o,
  input  logic      queue_full_i,
  input  logic      stream_done_i
);

  localparam int VDEPTH  = SLOT_DEPTH * MAX_VALUE_BYTES;
  localparam int VAW     = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int SW      = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int USE_MAX = (SLOT_DEPTH < SLOT_COUNT_MAX) ? SLOT_DEPTH : SLOT_COUNT_MAX;
  localparam int OW      = $clog2(USE_MAX + 1);
  localparam int CW      = (SW + 1 > OW) ? SW + 1 : OW;
  localparam int DQW     = $clog2(QDEPTH + 2);

  fe_state_e         state_q, state_d;
  logic [SW-1:0]     rd_slot_q, rd_slot_d;
  logic [SW-1:0]     wr_slot_q, wr_slot_d;
  logic [OW-1:0]     occ_q, occ_d;
  logic [LEN_W-1:0]  blen_q, blen_d;
  status_e           bfault_q, bfault_d;
  logic [4:0]        slot_count_q, slot_count_d;
  logic [6:0]        max_bytes_q, max_bytes_d;
  logic [6:0]        room_q;
  logic [DQW-1:0]    dq_cnt_q, dq_cnt_d;

  cmd_e              cmd;
  logic              accept;
  logic              full;
  logic [OW-1:0]     in_use;
  logic [LEN_W-1:0]  limit;
  logic [6:0]        room_sat;
  logic [SW-1:0]     wr_next, rd_next;
  logic              len_we, len_re;
  logic [LEN_W-1:0]  len_rdata, len_clamp;
  logic              lk_invalid;
  logic              stream_push;

  assign cmd      = cmd_e'(command_i);
  assign in_use   = (slot_count_q > 5'(USE_MAX)) ? OW'(USE_MAX) : OW'(slot_count_q);
  assign full     = (occ_q >= in_use);
  assign limit    = (max_bytes_q > 7'(MAX_VALUE_BYTES)) ? 7'(MAX_VALUE_BYTES) : max_bytes_q;
  assign room_sat = (room_bytes_i > 7'(ROOM_MAX)) ? 7'(ROOM_MAX) : room_bytes_i;
  assign wr_next  = (CW'(wr_slot_q) + CW'(1) >= CW'(in_use)) ? '0 : wr_slot_q + SW'(1);
  assign rd_next  = (CW'(rd_slot_q) + CW'(1) >= CW'(in_use)) ? '0 : rd_slot_q + SW'(1);

  assign len_clamp  = (len_rdata > 7'(MAX_VALUE_BYTES)) ? 7'(MAX_VALUE_BYTES) : len_rdata;
  assign lk_invalid = (len_clamp > room_q);

  assign cfg_o.slot_count      = slot_count_q;
  assign cfg_o.max_value_bytes = max_bytes_q;

  assign accept   = in_valid_i && !in_stall_o;
  assign vwaddr_o = VAW'(wr_slot_q * MAX_VALUE_BYTES) + VAW'(blen_q);
  assign vwdata_o = data_byte_i;

  vrf_ram #(
    .WIDTH(LEN_W),
    .DEPTH(SLOT_DEPTH)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (len_we),
    .waddr_i(wr_slot_q),
    .wdata_i(blen_q),
    .re_i   (len_re),
    .raddr_i(rd_slot_q),
    .rdata_o(len_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FE_IDLE: begin
        if (accept && cmd == CMD_DEQUEUE && occ_q != '0) begin
          state_d = FE_LOOKUP;
        end
      end
      FE_LOOKUP: begin
        if (!queue_full_i) begin
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = 1'b1;
    job_push_o  = 1'b0;
    job_o       = '{stream: 1'b0, status: ST_OK, slot: '0, len: '0};
    vwe_o       = 1'b0;
    len_we      = 1'b0;
    len_re      = 1'b0;
    stream_push = 1'b0;
    case (state_q)
      FE_IDLE: begin
        // appends wait while a dequeued record is still being read out
        in_stall_o = queue_full_i || (cmd == CMD_APPEND && dq_cnt_q != '0);
        if (accept) begin
          job_push_o = 1'b1;
          case (cmd)
            CMD_APPEND: begin
              if (full) begin
                job_o.status = ST_FULL;
              end else if (blen_q >= limit) begin
                job_o.status = ST_INVALID;
              end else begin
                vwe_o = 1'b1;
              end
            end
            CMD_COMMIT: begin
              if (bfault_q == ST_INVALID || blen_q > limit) begin
                job_o.status = ST_INVALID;
              end else if (bfault_q == ST_FULL || full) begin
                job_o.status = ST_FULL;
              end else begin
                len_we = 1'b1;
              end
            end
            CMD_DEQUEUE: begin
              if (occ_q == '0) begin
                job_o.status = ST_EMPTY;
              end else begin
                job_push_o = 1'b0;
                len_re     = 1'b1;
              end
            end
            default: job_o.status = ST_INVALID;
          endcase
        end
      end
      FE_LOOKUP: begin
        in_stall_o = 1'b1;
        if (!queue_full_i) begin
          job_push_o = 1'b1;
          if (lk_invalid) begin
            job_o.status = ST_INVALID;
          end else if (len_clamp != '0) begin
            job_o.stream = 1'b1;
            job_o.slot   = SLOT_FIELD_W'(rd_slot_q);
            job_o.len    = len_clamp;
            stream_push  = 1'b1;
          end
        end
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // ring and build state
  always_comb begin
    rd_slot_d    = rd_slot_q;
    wr_slot_d    = wr_slot_q;
    occ_d        = occ_q;
    blen_d       = blen_q;
    bfault_d     = bfault_q;
    slot_count_d = slot_count_q;
    max_bytes_d  = max_bytes_q;
    dq_cnt_d     = dq_cnt_q;
    if (state_q == FE_IDLE && accept) begin
      case (cmd)
        CMD_APPEND: begin
          if (full) begin
            if (bfault_q != ST_INVALID) begin
              bfault_d = ST_FULL;
            end
          end else if (blen_q >= limit) begin
            bfault_d = ST_INVALID;
          end else begin
            blen_d = blen_q + LEN_W'(1);
          end
        end
        CMD_COMMIT: begin
          if (len_we) begin
            wr_slot_d = wr_next;
            occ_d     = occ_q + OW'(1);
          end
          blen_d   = '0;
          bfault_d = ST_OK;
        end
        default: ;
      endcase
    end
    if (state_q == FE_LOOKUP && job_push_o && !lk_invalid) begin
      rd_slot_d = rd_next;
      occ_d     = occ_q - OW'(1);
    end
    if (stream_push && !stream_done_i) begin
      dq_cnt_d = dq_cnt_q + DQW'(1);
    end else if (!stream_push && stream_done_i) begin
      dq_cnt_d = dq_cnt_q - DQW'(1);
    end
    if (cfg_wr_i.slot_count_we) begin
      slot_count_d = (cfg_wr_i.data[4:0] > 5'(SLOT_COUNT_MAX)) ?
                     5'(SLOT_COUNT_MAX) : cfg_wr_i.data[4:0];
      rd_slot_d    = '0;
      wr_slot_d    = '0;
      occ_d        = '0;
      blen_d       = '0;
      bfault_d     = ST_OK;
    end
    if (cfg_wr_i.max_bytes_we) begin
      max_bytes_d = cfg_wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FE_IDLE;
      rd_slot_q    <= '0;
      wr_slot_q    <= '0;
      occ_q        <= '0;
      blen_q       <= '0;
      bfault_q     <= ST_OK;
      slot_count_q <= 5'(SLOT_COUNT_MAX);
      max_bytes_q  <= 7'(ROOM_MAX);
      dq_cnt_q     <= '0;
    end else begin
      state_q      <= state_d;
      rd_slot_q    <= rd_slot_d;
      wr_slot_q    <= wr_slot_d;
      occ_q        <= occ_d;
      blen_q       <= blen_d;
      bfault_q     <= bfault_d;
      slot_count_q <= slot_count_d;
      max_bytes_q  <= max_bytes_d;
      dq_cnt_q     <= dq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_re) begin
      room_q <= room_sat;
    end
  end

endmodule

/* src/vrf_back.sv */
// Back end: takes jobs from the queue, reads record bytes from the value store
// and drives the result channel through an output register with a skid entry.
// Depends on vrf_pkg.
`timescale 1ns / 1ps

module vrf_back
  import vrf_pkg::*;
#(
  parameter int SLOT_DEPTH      = 16,
  parameter int MAX_VALUE_BYTES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  job_t             job_i,
  input  logic             job_empty_i,
  output logic             job_pop_o,
  output logic             vre_o,
  output logic [((SLOT_DEPTH * MAX_VALUE_BYTES > 1) ?
                 $clog2(SLOT_DEPTH * MAX_VALUE_BYTES) : 1)-1:0] vraddr_o,
  input  logic [7:0]       vrdata_i,
  output logic             stream_done_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic [LEN_W-1:0] value_length_o,
  output logic             last_o
);

  localparam int VDEPTH = SLOT_DEPTH * MAX_VALUE_BYTES;
  localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;

  logic             act_q;
  job_t             job_q;
  logic [VAW-1:0]   base_q;
  logic [LEN_W-1:0] idx_q;
  logic             s1_v_q;
  res_t             s1_q;
  logic             o_v_q, k_v_q;
  res_t             o_q, k_q;
  logic [7:0]       o_byte_q, k_byte_q;

  logic             pop_out;
  logic [1:0]       held;
  logic             issue, is_last;
  res_t             s1_d;
  logic [7:0]       s1_byte;
  logic             o_load;

  assign pop_out = o_v_q && !out_stall_i;
  // entries that will need a place in the output register or skid
  assign held    = 2'(o_v_q) + 2'(k_v_q) + 2'(s1_v_q) - 2'(pop_out);
  assign issue   = act_q && (held < 2'd2);
  assign is_last = !job_q.stream || (idx_q + LEN_W'(1) == job_q.len);

  assign stream_done_o = issue && job_q.stream && is_last;
  assign job_pop_o     = !job_empty_i && (!act_q || (issue && is_last));
  assign vre_o         = issue && job_q.stream;
  assign vraddr_o      = base_q + VAW'(idx_q);

  always_comb begin
    s1_d.status       = job_q.status;
    s1_d.byte_valid   = job_q.stream;
    s1_d.value_length = job_q.stream ? job_q.len : '0;
    s1_d.last         = is_last;
  end

  assign s1_byte = s1_q.byte_valid ? vrdata_i : 8'd0;
  assign o_load  = !o_v_q || pop_out;

  assign out_valid_o    = o_v_q;
  assign status_o       = o_q.status;
  assign out_byte_o     = o_byte_q;
  assign byte_valid_o   = o_q.byte_valid;
  assign value_length_o = o_q.value_length;
  assign last_o         = o_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      s1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
      k_v_q  <= 1'b0;
    end else begin
      if (job_pop_o) begin
        act_q <= 1'b1;
      end else if (issue && is_last) begin
        act_q <= 1'b0;
      end
      s1_v_q <= issue;
      if (o_load) begin
        if (k_v_q) begin
          o_v_q <= 1'b1;
          k_v_q <= s1_v_q;
        end else begin
          o_v_q <= s1_v_q;
          k_v_q <= 1'b0;
        end
      end else if (s1_v_q) begin
        k_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q  <= job_i;
      base_q <= VAW'(job_i.slot * MAX_VALUE_BYTES);
      idx_q  <= '0;
    end else if (issue) begin
      idx_q <= idx_q + LEN_W'(1);
    end
    if (issue) begin
      s1_q <= s1_d;
    end
    if (o_load) begin
      if (k_v_q) begin
        o_q      <= k_q;
        o_byte_q <= k_byte_q;
        k_q      <= s1_q;
        k_byte_q <= s1_byte;
      end else begin
        o_q      <= s1_q;
        o_byte_q <= s1_byte;
      end
    end else if (s1_v_q) begin
      k_q      <= s1_q;
      k_byte_q <= s1_byte;
    end
  end

endmodule

/* src/variable_record_ring_fifo.sv */
// Top level of the variable record ring FIFO: register port, front end,
// job queue, back end and value store.
// Depends on vrf_pkg, vrf_ram, vrf_queue, vrf_front, vrf_back.
`timescale 1ns / 1ps

// Ring FIFO of byte records of varying length.
// Request channel (in_valid_i / in_stall_o): command_i selects append byte,
// commit record or dequeue record; data_byte_i and room_bytes_i go with it.
// Result channel (out_valid_o / out_stall_i): one result per request, or one
// result per byte of a successfully dequeued non-empty record; last_o marks the last one.
// Throughput: append and commit requests are taken one per cycle while the job
// queue has room. A dequeue holds the request side during its length store
// lookup, and longer while the job queue is full. An append waits until the
// bytes of every dequeued record have been read from the value store, which
// has one write and one read port. The result side sends one result per cycle
// while out_stall_i is low.
// When out_stall_i is high, results pile up in the output register, its skid
// entry and the 2-entry job queue; once those are full the request side stalls.
// Reset empties the ring, clears the record under construction and sets
// slot_count to 16 and max_value_bytes to 64; the stores are left as they are.
// Registers: slot_count at 0x0 (any write flushes the ring), max_value_bytes
// at 0x4. Write them only while the block is idle.
module variable_record_ring_fifo
  import vrf_pkg::*;
#(
  parameter int SLOT_DEPTH      = 16,
  parameter int MAX_VALUE_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  input  logic [6:0]  room_bytes_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic [6:0]  value_length_o,
  output logic        last_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int VDEPTH = SLOT_DEPTH * MAX_VALUE_BYTES;
  localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;

  cfg_wr_t        cfg_wr;
  cfg_view_t      cfg_view;
  reg_idx_e       reg_idx;
  logic           apb_write;

  logic           vwe, vre;
  logic [VAW-1:0] vwaddr, vraddr;
  logic [7:0]     vwdata, vrdata;

  logic           job_push, job_pop, q_full, q_empty, stream_done;
  job_t           job_in, job_out;

  // register port: always ready, word-aligned registers
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[2]);
  assign apb_write = psel && penable && pwrite;

  always_comb begin
    cfg_wr.slot_count_we = apb_write && (reg_idx == REG_SLOT_COUNT);
    cfg_wr.max_bytes_we  = apb_write && (reg_idx == REG_MAX_VALUE_BYTES);
    cfg_wr.data          = pwdata[6:0];
  end

  always_comb begin
    case (reg_idx)
      REG_SLOT_COUNT:      prdata = {27'd0, cfg_view.slot_count};
      REG_MAX_VALUE_BYTES: prdata = {25'd0, cfg_view.max_value_bytes};
      default:             prdata = '0;
    endcase
  end

  vrf_front #(
    .SLOT_DEPTH     (SLOT_DEPTH),
    .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .room_bytes_i (room_bytes_i),
    .cfg_wr_i     (cfg_wr),
    .cfg_o        (cfg_view),
    .vwe_o        (vwe),
    .vwaddr_o     (vwaddr),
    .vwdata_o     (vwdata),
    .job_push_o   (job_push),
    .job_o        (job_in),
    .queue_full_i (q_full),
    .stream_done_i(stream_done)
  );

  vrf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_data_i(job_in),
    .full_o     (q_full),
    .pop_i      (job_pop),
    .pop_data_o (job_out),
    .empty_o    (q_empty)
  );

  // value store: one fixed-stride region of MAX_VALUE_BYTES per slot
  vrf_ram #(
    .WIDTH(8),
    .DEPTH(VDEPTH)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (vwe),
    .waddr_i(vwaddr),
    .wdata_i(vwdata),
    .re_i   (vre),
    .raddr_i(vraddr),
    .rdata_o(vrdata)
  );

  vrf_back #(
    .SLOT_DEPTH     (SLOT_DEPTH),
    .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_out),
    .job_empty_i   (q_empty),
    .job_pop_o     (job_pop),
    .vre_o         (vre),
    .vraddr_o      (vraddr),
    .vrdata_i      (vrdata),
    .stream_done_o (stream_done),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .value_length_o(value_length_o),
    .last_o        (last_o)
  );

endmodule
